// ----- hdl/chp_pkg.sv -----
// ----------------------------------------------------------------------------
// chp_pkg
// Types, constants and code tables for the cartridge header parser.
// ----------------------------------------------------------------------------
package chp_pkg;

   localparam int unsigned SizeWidth = 25;

   localparam logic [8:0] OFS_FIRST   = 9'h134;
   localparam logic [8:0] OFS_TYPE    = 9'h147;
   localparam logic [8:0] OFS_ROMCODE = 9'h148;
   localparam logic [8:0] OFS_RAMCODE = 9'h149;
   localparam logic [8:0] OFS_CHECK   = 9'h14D;

   localparam logic [SizeWidth-1:0] HEADER_END = 25'h150;
   localparam int unsigned          BankShift  = 14;

   localparam logic [7:0] ROM_CODE_MAX = 8'h08;
   localparam logic [7:0] ROM_CODE_72  = 8'h52;
   localparam logic [7:0] ROM_CODE_80  = 8'h53;
   localparam logic [7:0] ROM_CODE_96  = 8'h54;

   localparam logic [7:0] RAM_CODE_2K   = 8'h01;
   localparam logic [7:0] RAM_CODE_8K   = 8'h02;
   localparam logic [7:0] RAM_CODE_32K  = 8'h03;
   localparam logic [7:0] RAM_CODE_128K = 8'h04;
   localparam logic [7:0] RAM_CODE_64K  = 8'h05;

   typedef struct packed {
      logic [7:0] header_byte;
      logic [8:0] byte_offset;
   } req_item_type;

   typedef struct packed {
      logic                 header_valid;
      logic [7:0]           mapper_code;
      logic [9:0]           rom_bank_num;
      logic [4:0]           ram_bank_num;
      logic [7:0]           check_byte;
      logic [SizeWidth-1:0] usable_rom_size;
   } rsp_item_type;

   function automatic logic [9:0] rom_banks(input logic [7:0] code);
      logic [9:0] banks;
      banks = 10'd2;
      if (code <= ROM_CODE_MAX) begin
         banks = 10'd2 << code[3:0];
      end else begin
         case (code)
            ROM_CODE_72: banks = 10'd72;
            ROM_CODE_80: banks = 10'd80;
            ROM_CODE_96: banks = 10'd96;
            default:     banks = 10'd2;
         endcase
      end
      return banks;
   endfunction

   function automatic logic [4:0] ram_banks(input logic [7:0] code);
      logic [4:0] banks;
      case (code)
         RAM_CODE_2K, RAM_CODE_8K: banks = 5'd1;
         RAM_CODE_32K:             banks = 5'd4;
         RAM_CODE_128K:            banks = 5'd16;
         RAM_CODE_64K:             banks = 5'd8;
         default:                  banks = 5'd0;
      endcase
      return banks;
   endfunction

   function automatic logic type_supported(input logic [7:0] t);
      return t inside {[8'h00:8'h03], [8'h0F:8'h13], [8'h19:8'h1E]};
   endfunction

endpackage

// ----- hdl/chp_in_stage.sv -----
// ----------------------------------------------------------------------------
// chp_in_stage
// Input register: holds one request word until the core consumes it.
// ----------------------------------------------------------------------------
module chp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  chp_pkg::req_item_type req_data,
   input  logic                  advance,
   output logic                  item_valid,
   output chp_pkg::req_item_type item
);
   import chp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/chp_hdr_core.sv -----
// ----------------------------------------------------------------------------
// chp_hdr_core
// Header state (checksum accumulator, captured codes) and result evaluation.
// ----------------------------------------------------------------------------
module chp_hdr_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  chp_pkg::req_item_type         item,
   input  logic [chp_pkg::SizeWidth-1:0] available_size,
   output chp_pkg::rsp_item_type         result
);
   import chp_pkg::*;

   logic [7:0] acc_ff, acc_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] rom_code_ff, rom_code_in;
   logic [7:0] ram_code_ff, ram_code_in;

   logic                 body_byte;
   logic [7:0]           acc_base;
   logic [9:0]           rom_count;
   logic [SizeWidth-1:0] bank_bytes;
   logic                 pass;

   assign body_byte = (item.byte_offset >= OFS_FIRST) && (item.byte_offset < OFS_CHECK);
   assign acc_base  = (item.byte_offset == OFS_FIRST) ? 8'h00 : acc_ff;

   always_comb begin
      acc_in      = acc_ff;
      type_in     = type_ff;
      rom_code_in = rom_code_ff;
      ram_code_in = ram_code_ff;
      if (step && body_byte) begin
         acc_in = acc_base - item.header_byte - 8'd1;
         case (item.byte_offset)
            OFS_TYPE:    type_in     = item.header_byte;
            OFS_ROMCODE: rom_code_in = item.header_byte;
            OFS_RAMCODE: ram_code_in = item.header_byte;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= 8'h00;
         type_ff     <= 8'h00;
         rom_code_ff <= 8'h00;
         ram_code_ff <= 8'h00;
      end else begin
         acc_ff      <= acc_in;
         type_ff     <= type_in;
         rom_code_ff <= rom_code_in;
         ram_code_ff <= ram_code_in;
      end
   end

   assign rom_count  = rom_banks(rom_code_ff);
   assign bank_bytes = SizeWidth'(rom_count) << BankShift;
   assign pass       = (available_size >= HEADER_END) && (acc_ff == item.header_byte)
                       && type_supported(type_ff);

   always_comb begin
      result = '0;
      if (pass) begin
         result.header_valid    = 1'b1;
         result.mapper_code     = type_ff;
         result.rom_bank_num    = rom_count;
         result.ram_bank_num    = ram_banks(ram_code_ff);
         result.check_byte      = item.header_byte;
         result.usable_rom_size = (bank_bytes > available_size) ? available_size : bank_bytes;
      end
   end

endmodule

// ----- hdl/chp_out_stage.sv -----
// ----------------------------------------------------------------------------
// chp_out_stage
// Result register towards the response channel.
// ----------------------------------------------------------------------------
module chp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  chp_pkg::rsp_item_type result,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output chp_pkg::rsp_item_type rsp_data
);
   import chp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hdl/cartridge_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// cartridge_header_parser_top
// Header checksum check and bank decode over a stream of ROM bytes.
//
//  channel | ports                                   | word
//  --------+-----------------------------------------+---------------------
//  req     | req_valid, req_ready, req_data          | ROM byte + offset
//  rsp     | rsp_valid, rsp_ready, rsp_data          | header decode result
//  csr     | csr_valid, csr_ready, csr_available_size| available ROM size
//
//  One word per cycle unless a checksum word is held. A word is evaluated while
//  in the input register; a checksum word's result is registered as it leaves.
//  Synchronous reset clears the header state and available size to zero.
//  A result waiting in the result register holds the next checksum word in
//  the input register, and the request channel with it; other bytes pass.
//  csr writes are always taken.
// ----------------------------------------------------------------------------
module cartridge_header_parser_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  chp_pkg::req_item_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output chp_pkg::rsp_item_type         rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [chp_pkg::SizeWidth-1:0] csr_available_size
);
   import chp_pkg::*;

   logic [SizeWidth-1:0] avail_ff;
   logic [SizeWidth-1:0] avail_in;
   logic                 item_valid;
   req_item_type         item;
   logic                 is_check;
   logic                 out_free;
   logic                 advance;
   rsp_item_type         result;

   assign csr_ready = 1'b1;

   always_comb begin
      avail_in = avail_ff;
      if (csr_valid) begin
         avail_in = csr_available_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
      end
   end

   assign is_check = (item.byte_offset == OFS_CHECK);
   assign advance  = item_valid && (!is_check || out_free);

   chp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   chp_hdr_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (item),
      .available_size (avail_ff),
      .result         (result)
   );

   chp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && is_check),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cartridge_header_parser_top. ROM words (byte plus
// offset) are streamed in: sparse and complete headers, broken sequences and
// out-of-window noise, under several available-size settings, with random
// idling on both channels and one long receiver hold-off. A running model of
// the header checksum and bank decode predicts every result, and each result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import chp_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int IDLE_PCT      = 15;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_WORDS   = 185;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [7:0] MAPPER_A_FIRST = 8'h00;
   localparam logic [7:0] MAPPER_A_LAST  = 8'h03;
   localparam logic [7:0] MAPPER_B_FIRST = 8'h0F;
   localparam logic [7:0] MAPPER_B_LAST  = 8'h13;
   localparam logic [7:0] MAPPER_C_FIRST = 8'h19;
   localparam logic [7:0] MAPPER_C_LAST  = 8'h1E;

   localparam logic [SizeWidth-1:0] SIZE_FULL = 25'h1000000;
   localparam logic [SizeWidth-1:0] SIZE_MAX  = 25'h1FFFFFF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_item_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SizeWidth-1:0] csr_available_size = '0;

   // header model state
   logic [7:0]           rom_sum       = 8'h00;
   logic [7:0]           rom_type      = 8'h00;
   logic [7:0]           rom_code_seen = 8'h00;
   logic [7:0]           ram_code_seen = 8'h00;
   logic [SizeWidth-1:0] avail_size    = '0;
   rsp_item_type         expected_headers[$];

   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   bit hold_request = 1'b0;
   int hold_left    = 0;

   int fail_count         = 0;
   int words_sent         = 0;
   int window_words       = 0;
   int results_checked    = 0;
   int valid_headers      = 0;
   int clamped_headers    = 0;
   int size_settings      = 0;
   int input_stall_cycles = 0;
   int cycle_count        = 0;

   cartridge_header_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_available_size (csr_available_size)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic int unsigned rom_bank_total(input logic [7:0] code);
      if (code <= ROM_CODE_MAX) return 2 << code;
      case (code)
         ROM_CODE_72: return 72;
         ROM_CODE_80: return 80;
         ROM_CODE_96: return 96;
         default:     return 2;
      endcase
   endfunction

   function automatic int unsigned ram_bank_total(input logic [7:0] code);
      case (code)
         RAM_CODE_2K, RAM_CODE_8K: return 1;
         RAM_CODE_32K:             return 4;
         RAM_CODE_128K:            return 16;
         RAM_CODE_64K:             return 8;
         default:                  return 0;
      endcase
   endfunction

   function automatic bit mapper_supported(input logic [7:0] t);
      return (t <= MAPPER_A_LAST) || (t >= MAPPER_B_FIRST && t <= MAPPER_B_LAST) ||
             (t >= MAPPER_C_FIRST && t <= MAPPER_C_LAST);
   endfunction

   function automatic void decode_header_word(input req_item_type w);
      rsp_item_type r;
      int unsigned  banks;
      int unsigned  rom_bytes;
      if (w.byte_offset < OFS_FIRST || w.byte_offset > OFS_CHECK) return;
      window_words++;
      if (w.byte_offset != OFS_CHECK) begin
         if (w.byte_offset == OFS_FIRST) rom_sum = 8'h00;
         rom_sum = rom_sum - w.header_byte - 8'd1;
         case (w.byte_offset)
            OFS_TYPE:    rom_type      = w.header_byte;
            OFS_ROMCODE: rom_code_seen = w.header_byte;
            OFS_RAMCODE: ram_code_seen = w.header_byte;
            default: ;
         endcase
         return;
      end
      r = '0;
      if (avail_size >= HEADER_END && rom_sum == w.header_byte && mapper_supported(rom_type)) begin
         banks     = rom_bank_total(rom_code_seen);
         rom_bytes = banks << BankShift;
         r.header_valid = 1'b1;
         r.mapper_code  = rom_type;
         r.rom_bank_num = banks[9:0];
         r.ram_bank_num = 5'(ram_bank_total(ram_code_seen));
         r.check_byte   = w.header_byte;
         if (rom_bytes > avail_size) begin
            r.usable_rom_size = avail_size;
            clamped_headers++;
         end else begin
            r.usable_rom_size = rom_bytes[SizeWidth-1:0];
         end
      end
      expected_headers.push_back(r);
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_headers.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual 0x%0h", $time, rsp_data);
         end else begin
            want = expected_headers.pop_front();
            check_field("header_valid", 32'(want.header_valid), 32'(rsp_data.header_valid));
            check_field("mapper_code", 32'(want.mapper_code), 32'(rsp_data.mapper_code));
            check_field("rom_bank_num", 32'(want.rom_bank_num), 32'(rsp_data.rom_bank_num));
            check_field("ram_bank_num", 32'(want.ram_bank_num), 32'(rsp_data.ram_bank_num));
            check_field("check_byte", 32'(want.check_byte), 32'(rsp_data.check_byte));
            check_field("usable_rom_size", 32'(want.usable_rom_size),
                        32'(rsp_data.usable_rom_size));
            results_checked++;
            if (want.header_valid) valid_headers++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && !req_ready) input_stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_headers.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(rsp_idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_word(input logic [7:0] b, input logic [8:0] ofs);
      req_item_type w;
      w.header_byte = b;
      w.byte_offset = ofs;
      if (req_idle_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_header_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_available_size(input logic [SizeWidth-1:0] v);
      csr_valid          <= 1'b1;
      csr_available_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      avail_size = v;
      size_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sparse_header(input logic [7:0] first, input logic [7:0] t,
                                     input logic [7:0] rc, input logic [7:0] mc,
                                     input bit good);
      send_word(first, OFS_FIRST);
      send_word(t, OFS_TYPE);
      send_word(rc, OFS_ROMCODE);
      send_word(mc, OFS_RAMCODE);
      send_word(good ? rom_sum : ~rom_sum, OFS_CHECK);
   endtask

   // full header with random content; some have dropped or repeated words
   task automatic send_random_header();
      logic [7:0] t;
      logic [7:0] rc;
      logic [7:0] mc;
      logic [7:0] b;
      bit         broken;
      if ($urandom_range(99) < 70) begin
         case ($urandom_range(2))
            0:       t = 8'($urandom_range(MAPPER_A_LAST, MAPPER_A_FIRST));
            1:       t = 8'($urandom_range(MAPPER_B_LAST, MAPPER_B_FIRST));
            default: t = 8'($urandom_range(MAPPER_C_LAST, MAPPER_C_FIRST));
         endcase
      end else begin
         t = 8'($urandom);
      end
      case ($urandom_range(4))
         0, 1, 2: rc = 8'($urandom_range(ROM_CODE_MAX, 0));
         3:       rc = 8'($urandom_range(ROM_CODE_96, ROM_CODE_72));
         default: rc = 8'($urandom);
      endcase
      mc     = ($urandom_range(99) < 75) ? 8'($urandom_range(RAM_CODE_64K, 0)) : 8'($urandom);
      broken = ($urandom_range(99) < 15);
      repeat ($urandom_range(2))
         send_word(8'($urandom), 9'($urandom_range(OFS_FIRST - 1, 0)));
      for (int o = int'(OFS_FIRST); o < OFS_CHECK; o++) begin
         case (9'(o))
            OFS_TYPE:    b = t;
            OFS_ROMCODE: b = rc;
            OFS_RAMCODE: b = mc;
            default:     b = 8'($urandom);
         endcase
         if (!(broken && $urandom_range(9) == 0)) begin
            send_word(b, 9'(o));
            if (broken && $urandom_range(9) == 0) send_word(b, 9'(o));
         end
      end
      send_word(($urandom_range(99) < 80) ? rom_sum : 8'($urandom), OFS_CHECK);
      repeat ($urandom_range(1))
         send_word(8'($urandom), 9'($urandom_range(9'h1FF, OFS_CHECK + 1)));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      send_word(8'h00, OFS_CHECK);
      drain_block();
      write_available_size(SIZE_FULL);
      send_word(8'h00, OFS_CHECK);
   endtask

   task automatic test_ignored_offsets();
      send_word(8'hFF, 9'h000);
      send_word(8'hFF, OFS_FIRST - 9'd1);
      send_word(8'hFF, OFS_CHECK + 9'd1);
      send_word(8'hFF, 9'h1FF);
      send_word(8'h00, OFS_CHECK);
   endtask

   task automatic test_sparse_headers();
      send_sparse_header(8'hFF, MAPPER_C_LAST, ROM_CODE_96, RAM_CODE_128K, 1'b1);
      send_sparse_header(8'h00, MAPPER_B_LAST, ROM_CODE_MAX, RAM_CODE_64K, 1'b0);
      send_sparse_header(8'h7F, MAPPER_A_LAST + 8'd1, ROM_CODE_72, RAM_CODE_32K, 1'b1);
   endtask

   task automatic test_backpressure();
      drain_block();
      write_available_size(SIZE_FULL);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random_header();
      req_valid <= 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      repeat (40) send_word($urandom_range(1) ? rom_sum : 8'($urandom), OFS_CHECK);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_headers();
      logic [SizeWidth-1:0] size_plan[8];
      int                   start;
      size_plan = '{25'd0, HEADER_END - 25'd1, HEADER_END,
                    25'($urandom_range(25'h20000, HEADER_END)), 25'h7FFF, SIZE_FULL, SIZE_MAX,
                    25'($urandom)};
      foreach (size_plan[p]) begin
         drain_block();
         write_available_size(size_plan[p]);
         req_idle_on = (p != 2);
         rsp_idle_on = (p != 2);
         start = window_words;
         while (window_words - start < PHASE_WORDS) begin
            if ($urandom_range(99) < 10) begin
               repeat ($urandom_range(4, 1)) begin
                  if ($urandom_range(1))
                     send_word(8'($urandom), 9'($urandom));
                  else
                     send_word(8'($urandom), 9'($urandom_range(OFS_CHECK, OFS_FIRST)));
               end
            end else begin
               send_random_header();
            end
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_ignored_offsets();
      test_sparse_headers();
      test_backpressure();
      test_random_headers();
      drain_block();
      $display("Sent %0d words (%0d in the header window) under %0d size settings",
               words_sent, window_words, size_settings);
      $display("Checked %0d results: %0d valid, %0d clamped; %0d input stall cycles",
               results_checked, valid_headers, clamped_headers, input_stall_cycles);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/chp_pkg.sv
hdl/chp_in_stage.sv
hdl/chp_hdr_core.sv
hdl/chp_out_stage.sv
hdl/cartridge_header_parser_top.sv
dv/testbench.sv
